/* rtl/psu_pkg.sv */
// ----------------------------------------------------------------------------
// psu_pkg
// Shared widths, register indexes, control types and helpers for the
// particle swarm update unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psu_pkg;

   localparam int NUM_PARTICLES_DEF = 32;

   localparam int IDX_W   = 5;
   localparam int POS_W   = 15;
   localparam int FIT_W   = 29;
   localparam int GAIN_W  = 10;
   localparam int LIM_W   = 14;
   localparam int RAND_W  = 16;
   localparam int CSR_IW  = 3;
   localparam int CSR_DW  = 14;

   localparam logic [GAIN_W-1:0] COG_GAIN_RST = GAIN_W'(384);
   localparam logic [GAIN_W-1:0] SOC_GAIN_RST = GAIN_W'(384);
   localparam logic [GAIN_W-1:0] INERTIA_RST  = GAIN_W'(256);
   localparam logic [LIM_W-1:0]  SPEED_RST    = LIM_W'(1024);
   localparam logic [LIM_W-1:0]  POSLIM_RST   = LIM_W'(10240);

   localparam logic [CSR_IW-1:0] REG_COG_GAIN = 3'd0;
   localparam logic [CSR_IW-1:0] REG_SOC_GAIN = 3'd1;
   localparam logic [CSR_IW-1:0] REG_INERTIA  = 3'd2;
   localparam logic [CSR_IW-1:0] REG_SPEED    = 3'd3;
   localparam logic [CSR_IW-1:0] REG_POSLIM   = 3'd4;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   typedef logic signed [POS_W-1:0] pos_type;
   typedef logic signed [FIT_W-1:0] fit_type;

   typedef struct packed {
      logic mul1;
      logic mul2;
      logic sum;
   } stage_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL1 = 7'b0000010,
      ST_MUL2 = 7'b0000100,
      ST_SUM  = 7'b0001000,
      ST_POS  = 7'b0010000,
      ST_SQR  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   // most negative code saturates to keep the range symmetric
   function automatic pos_type sat_load(input logic [POS_W-1:0] v);
      if (v == {1'b1, {(POS_W-1){1'b0}}}) begin
         sat_load = {1'b1, {(POS_W-2){1'b0}}, 1'b1};
      end else begin
         sat_load = pos_type'(v);
      end
   endfunction

endpackage

`default_nettype wire

/* rtl/psu_axis.sv */
// ----------------------------------------------------------------------------
// psu_axis
// One axis of the velocity update: gain products, pulls, inertia, clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psu_axis (
   input  wire                          clock,
   input  psu_pkg::stage_type           stage,
   input  wire [psu_pkg::GAIN_W-1:0]    cog_gain,
   input  wire [psu_pkg::GAIN_W-1:0]    soc_gain,
   input  wire [psu_pkg::GAIN_W-1:0]    inertia,
   input  wire [psu_pkg::LIM_W-1:0]     speed_limit,
   input  wire [psu_pkg::RAND_W-1:0]    rand_cog,
   input  wire [psu_pkg::RAND_W-1:0]    rand_soc,
   input  wire signed [psu_pkg::POS_W-1:0] pos,
   input  wire signed [psu_pkg::POS_W-1:0] vel,
   input  wire signed [psu_pkg::POS_W-1:0] pbest,
   input  wire signed [psu_pkg::POS_W-1:0] gbest,
   output logic signed [psu_pkg::POS_W-1:0] vel_new
);
   import psu_pkg::*;

   localparam int GR_W   = GAIN_W + RAND_W;
   localparam int DIF_W  = POS_W + 1;
   localparam int INR_W  = GAIN_W + 1 + POS_W;
   localparam int PRD_W  = GR_W + 1 + DIF_W;
   localparam int TP_W   = PRD_W - 24;
   localparam int TI_W   = INR_W - 8;
   localparam int SUM_W  = TP_W + 2;

   logic [GR_W-1:0]          gr_cog_ff, gr_soc_ff;
   logic signed [DIF_W-1:0]  dif_cog_ff, dif_soc_ff;
   logic signed [INR_W-1:0]  inr_ff;
   logic signed [TP_W-1:0]   tc_ff, ts_ff;
   logic signed [TI_W-1:0]   ti_ff;
   logic signed [PRD_W-1:0]  prod_cog, prod_soc;
   logic signed [SUM_W-1:0]  sum, lim;
   logic signed [POS_W-1:0]  vel_ff, vel_in;

   assign prod_cog = $signed({1'b0, gr_cog_ff}) * dif_cog_ff;
   assign prod_soc = $signed({1'b0, gr_soc_ff}) * dif_soc_ff;
   assign sum = SUM_W'(ti_ff) + SUM_W'(tc_ff) + SUM_W'(ts_ff);
   assign lim = $signed({{(SUM_W-LIM_W){1'b0}}, speed_limit});

   always_comb begin
      if (sum > lim) begin
         vel_in = POS_W'(lim);
      end else if (sum < -lim) begin
         vel_in = POS_W'(-lim);
      end else begin
         vel_in = POS_W'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (stage.mul1) begin
         gr_cog_ff  <= GR_W'(cog_gain) * GR_W'(rand_cog);
         gr_soc_ff  <= GR_W'(soc_gain) * GR_W'(rand_soc);
         dif_cog_ff <= DIF_W'(pbest) - DIF_W'(pos);
         dif_soc_ff <= DIF_W'(gbest) - DIF_W'(pos);
         inr_ff     <= $signed({1'b0, inertia}) * vel;
      end
      if (stage.mul2) begin
         tc_ff <= prod_cog[PRD_W-1:24];
         ts_ff <= prod_soc[PRD_W-1:24];
         ti_ff <= inr_ff[INR_W-1:8];
      end
      if (stage.sum) begin
         vel_ff <= vel_in;
      end
   end

   assign vel_new = vel_ff;

endmodule

`default_nettype wire

/* rtl/particle_swarm_update_unit.sv */
// ----------------------------------------------------------------------------
// particle_swarm_update_unit
// Global-best particle swarm engine, 2-D particles, fitness y*y - x*x.
// ----------------------------------------------------------------------------
//  channel  | ports                         | handshake
//  request  | start, busy, req_*            | beat taken on start && !busy
//  response | rsp_strobe, rsp_*             | one-cycle strobe, no back-pressure
//  config   | csr_write_en, csr_index/wdata | write on csr_write_en
//
// Update: read, two multiply stages, sum, position clamp, square, then
// write-back through the single particle memory. Load goes straight to
// the square step; an index out of range goes straight to the result.
// One item at a time; busy is high from accept until the result strobe.
// Synchronous reset clears control and the global best; the particle
// memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module particle_swarm_update_unit #(
   parameter int NUM_PARTICLES = psu_pkg::NUM_PARTICLES_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire                              req_opcode,
   input  wire [psu_pkg::IDX_W-1:0]         req_particle_index,
   input  wire signed [psu_pkg::POS_W-1:0]  req_load_pos_x,
   input  wire signed [psu_pkg::POS_W-1:0]  req_load_pos_y,
   input  wire signed [psu_pkg::POS_W-1:0]  req_load_vel_x,
   input  wire signed [psu_pkg::POS_W-1:0]  req_load_vel_y,
   input  wire [psu_pkg::RAND_W-1:0]        req_rand_cog_x,
   input  wire [psu_pkg::RAND_W-1:0]        req_rand_soc_x,
   input  wire [psu_pkg::RAND_W-1:0]        req_rand_cog_y,
   input  wire [psu_pkg::RAND_W-1:0]        req_rand_soc_y,
   output logic                             rsp_strobe,
   output logic [psu_pkg::IDX_W-1:0]        rsp_out_index,
   output logic signed [psu_pkg::POS_W-1:0] rsp_new_pos_x,
   output logic signed [psu_pkg::POS_W-1:0] rsp_new_pos_y,
   output logic signed [psu_pkg::FIT_W-1:0] rsp_fitness,
   output logic signed [psu_pkg::POS_W-1:0] rsp_best_x,
   output logic signed [psu_pkg::POS_W-1:0] rsp_best_y,
   output logic signed [psu_pkg::FIT_W-1:0] rsp_best_fitness,
   output logic                             rsp_personal_improved,
   output logic                             rsp_global_improved,
   input  wire                              csr_write_en,
   input  wire [psu_pkg::CSR_IW-1:0]        csr_index,
   input  wire [psu_pkg::CSR_DW-1:0]        csr_wdata
);
   import psu_pkg::*;

   localparam int AW    = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
   localparam int SQ_W  = FIT_W - 1;
   localparam int WORD_W = 6 * POS_W + FIT_W;

   typedef struct packed {
      fit_type pb_fit;
      pos_type pb_y;
      pos_type pb_x;
      pos_type vel_y;
      pos_type vel_x;
      pos_type pos_y;
      pos_type pos_x;
   } entry_type;

   logic [WORD_W-1:0] mem [NUM_PARTICLES];

   logic [GAIN_W-1:0] cog_ff, soc_ff, inr_ff;
   logic [LIM_W-1:0]  spd_ff, plim_ff;

   state_type state_ff, state_in;
   logic accept;
   logic op_ff, oor_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [RAND_W-1:0] rcx_ff, rsx_ff, rcy_ff, rsy_ff;
   entry_type rd_ff, wr;
   pos_type px_ff, py_ff, vx_ff, vy_ff;
   pos_type vx_new, vy_new;
   logic [SQ_W-1:0] xx_ff, yy_ff;
   logic signed [2*POS_W-1:0] sq_x, sq_y;
   logic signed [POS_W:0] sum_x, sum_y, plim;
   pos_type cx, cy;
   fit_type fit;
   logic pimp, gimp;

   pos_type gb_x_ff, gb_y_ff;
   fit_type gb_fit_ff;
   logic gb_valid_ff;

   stage_type stage;

   assign accept = start && !busy;
   assign busy = (state_ff != ST_IDLE);
   assign stage.mul1 = (state_ff == ST_MUL1);
   assign stage.mul2 = (state_ff == ST_MUL2);
   assign stage.sum  = (state_ff == ST_SUM);

   psu_axis u_axis_x (
      .clock(clock), .stage(stage), .cog_gain(cog_ff), .soc_gain(soc_ff),
      .inertia(inr_ff), .speed_limit(spd_ff), .rand_cog(rcx_ff), .rand_soc(rsx_ff),
      .pos(rd_ff.pos_x), .vel(rd_ff.vel_x), .pbest(rd_ff.pb_x), .gbest(gb_x_ff),
      .vel_new(vx_new)
   );

   psu_axis u_axis_y (
      .clock(clock), .stage(stage), .cog_gain(cog_ff), .soc_gain(soc_ff),
      .inertia(inr_ff), .speed_limit(spd_ff), .rand_cog(rcy_ff), .rand_soc(rsy_ff),
      .pos(rd_ff.pos_y), .vel(rd_ff.vel_y), .pbest(rd_ff.pb_y), .gbest(gb_y_ff),
      .vel_new(vy_new)
   );

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         cog_ff  <= COG_GAIN_RST;
         soc_ff  <= SOC_GAIN_RST;
         inr_ff  <= INERTIA_RST;
         spd_ff  <= SPEED_RST;
         plim_ff <= POSLIM_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_COG_GAIN: cog_ff  <= csr_wdata[GAIN_W-1:0];
            REG_SOC_GAIN: soc_ff  <= csr_wdata[GAIN_W-1:0];
            REG_INERTIA:  inr_ff  <= csr_wdata[GAIN_W-1:0];
            REG_SPEED:    spd_ff  <= csr_wdata[LIM_W-1:0];
            REG_POSLIM:   plim_ff <= csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (32'(req_particle_index) >= NUM_PARTICLES) begin
                  state_in = ST_DONE;
               end else if (req_opcode == OP_LOAD) begin
                  state_in = ST_SQR;
               end else begin
                  state_in = ST_MUL1;
               end
            end
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_SUM;
         ST_SUM:  state_in = ST_POS;
         ST_POS:  state_in = ST_SQR;
         ST_SQR:  state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // position clamp
   assign plim  = $signed({2'b00, plim_ff});
   assign sum_x = (POS_W+1)'(rd_ff.pos_x) + (POS_W+1)'(vx_new);
   assign sum_y = (POS_W+1)'(rd_ff.pos_y) + (POS_W+1)'(vy_new);

   always_comb begin
      if (sum_x > plim) begin
         cx = POS_W'(plim);
      end else if (sum_x < -plim) begin
         cx = POS_W'(-plim);
      end else begin
         cx = POS_W'(sum_x);
      end
      if (sum_y > plim) begin
         cy = POS_W'(plim);
      end else if (sum_y < -plim) begin
         cy = POS_W'(-plim);
      end else begin
         cy = POS_W'(sum_y);
      end
   end

   assign sq_x = px_ff * px_ff;
   assign sq_y = py_ff * py_ff;
   assign fit  = $signed({1'b0, yy_ff}) - $signed({1'b0, xx_ff});
   assign pimp = (op_ff == OP_LOAD) || (fit > rd_ff.pb_fit);
   assign gimp = !gb_valid_ff || (fit > gb_fit_ff);

   always_comb begin
      wr.pos_x  = px_ff;
      wr.pos_y  = py_ff;
      wr.vel_x  = vx_ff;
      wr.vel_y  = vy_ff;
      wr.pb_x   = pimp ? px_ff : rd_ff.pb_x;
      wr.pb_y   = pimp ? py_ff : rd_ff.pb_y;
      wr.pb_fit = pimp ? fit : rd_ff.pb_fit;
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff  <= entry_type'(mem[AW'(req_particle_index)]);
         op_ff  <= req_opcode;
         idx_ff <= req_particle_index;
         oor_ff <= (32'(req_particle_index) >= NUM_PARTICLES);
         rcx_ff <= req_rand_cog_x;
         rsx_ff <= req_rand_soc_x;
         rcy_ff <= req_rand_cog_y;
         rsy_ff <= req_rand_soc_y;
         px_ff  <= sat_load(req_load_pos_x);
         py_ff  <= sat_load(req_load_pos_y);
         vx_ff  <= sat_load(req_load_vel_x);
         vy_ff  <= sat_load(req_load_vel_y);
      end else if (state_ff == ST_POS) begin
         px_ff <= cx;
         py_ff <= cy;
         vx_ff <= vx_new;
         vy_ff <= vy_new;
      end
      if (state_ff == ST_SQR) begin
         xx_ff <= sq_x[SQ_W-1:0];
         yy_ff <= sq_y[SQ_W-1:0];
      end
      if ((state_ff == ST_DONE) && !oor_ff) begin
         mem[AW'(idx_ff)] <= wr;
      end
   end

   // global best and response
   always_ff @(posedge clock) begin
      if (reset) begin
         gb_x_ff     <= '0;
         gb_y_ff     <= '0;
         gb_fit_ff   <= '0;
         gb_valid_ff <= 1'b0;
         rsp_strobe  <= 1'b0;
      end else begin
         rsp_strobe <= (state_ff == ST_DONE);
         if ((state_ff == ST_DONE) && !oor_ff && gimp) begin
            gb_x_ff     <= px_ff;
            gb_y_ff     <= py_ff;
            gb_fit_ff   <= fit;
            gb_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE) begin
         rsp_out_index         <= idx_ff;
         rsp_new_pos_x         <= oor_ff ? '0 : px_ff;
         rsp_new_pos_y         <= oor_ff ? '0 : py_ff;
         rsp_fitness           <= oor_ff ? '0 : fit;
         rsp_best_x            <= (!oor_ff && gimp) ? px_ff : gb_x_ff;
         rsp_best_y            <= (!oor_ff && gimp) ? py_ff : gb_y_ff;
         rsp_best_fitness      <= (!oor_ff && gimp) ? fit : gb_fit_ff;
         rsp_personal_improved <= !oor_ff && pimp;
         rsp_global_improved   <= !oor_ff && gimp;
      end
   end

endmodule

`default_nettype wire

/* rtl/psu_checker.sv */
// ----------------------------------------------------------------------------
// psu_checker
// Port-level checks on the request/response sequencing of the unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psu_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              start,
   input wire                              busy,
   input wire                              rsp_strobe,
   input wire signed [psu_pkg::POS_W-1:0]  rsp_new_pos_x,
   input wire signed [psu_pkg::POS_W-1:0]  rsp_best_x,
   input wire signed [psu_pkg::FIT_W-1:0]  rsp_fitness,
   input wire signed [psu_pkg::FIT_W-1:0]  rsp_best_fitness,
   input wire                              rsp_global_improved
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted beat did not raise busy");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("result strobe while busy");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result repeated");

   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe) else $error("busy dropped without result");

   a_gbest: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_global_improved) |->
         (rsp_best_fitness == rsp_fitness && rsp_best_x == rsp_new_pos_x))
      else $error("global best does not match improving result");

endmodule

bind particle_swarm_update_unit psu_checker u_psu_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_new_pos_x(rsp_new_pos_x), .rsp_best_x(rsp_best_x),
   .rsp_fitness(rsp_fitness), .rsp_best_fitness(rsp_best_fitness),
   .rsp_global_improved(rsp_global_improved)
);

`default_nettype wire
